@@ rtl/wopi_pkg.sv @@
// ----------------------------------------------------------------------------
// wopi_pkg
// Shared types and constants for the wheel odometry pose integrator.
// ----------------------------------------------------------------------------
package wopi_pkg;

  localparam int ATAN_DEPTH = 24;

  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
  localparam logic signed [16:0] SQRT2_QUARTER = 17'sd23170;
  localparam logic signed [30:0] UNITS_PER_RAD = 31'sd683565276;

  localparam logic [2:0] REG_MODE    = 3'd0;
  localparam logic [2:0] REG_INV_RAD = 3'd1;
  localparam logic [2:0] REG_TSTEP   = 3'd2;
  localparam logic [2:0] REG_START_X = 3'd3;
  localparam logic [2:0] REG_START_Y = 3'd4;
  localparam logic [2:0] REG_START_H = 3'd5;

  // datapath commands from the controller
  typedef struct packed {
    logic load;   // capture wheels, velocity and rate, start cordic
    logic iter;   // one cordic rotation
    logic mul1;   // world velocity products
    logic mul2;   // velocity sums and shifts
    logic mul3;   // displacement and angle step products
    logic mul4;   // angle step scale
    logic commit; // update pose
  } wopi_cmd_t;

  typedef struct packed {
    logic last_iter;
  } wopi_sts_t;

  function automatic logic signed [33:0] atan_entry(input logic [4:0] i);
    logic signed [33:0] r;
    r = '0;
    case (i)
      5'd0:  r = 34'sd536870912;
      5'd1:  r = 34'sd316933406;
      5'd2:  r = 34'sd167458907;
      5'd3:  r = 34'sd85004756;
      5'd4:  r = 34'sd42667331;
      5'd5:  r = 34'sd21354465;
      5'd6:  r = 34'sd10679838;
      5'd7:  r = 34'sd5340245;
      5'd8:  r = 34'sd2670163;
      5'd9:  r = 34'sd1335087;
      5'd10: r = 34'sd667544;
      5'd11: r = 34'sd333772;
      5'd12: r = 34'sd166886;
      5'd13: r = 34'sd83443;
      5'd14: r = 34'sd41722;
      5'd15: r = 34'sd20861;
      5'd16: r = 34'sd10430;
      5'd17: r = 34'sd5215;
      5'd18: r = 34'sd2608;
      5'd19: r = 34'sd1304;
      5'd20: r = 34'sd652;
      5'd21: r = 34'sd326;
      5'd22: r = 34'sd163;
      5'd23: r = 34'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/wopi_ctrl.sv @@
// ----------------------------------------------------------------------------
// wopi_ctrl
// Sequencer: accept a request, run cordic, multiply steps, present result.
// ----------------------------------------------------------------------------
module wopi_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  wopi_pkg::wopi_sts_t sts,
  output wopi_pkg::wopi_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ITER = 3'd1;
  localparam logic [2:0] ST_M1   = 3'd2;
  localparam logic [2:0] ST_M2   = 3'd3;
  localparam logic [2:0] ST_M3   = 3'd4;
  localparam logic [2:0] ST_M4   = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;
  localparam logic [2:0] ST_CMT  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_OUT);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_ITER;
        end
      end
      ST_ITER: begin
        cmd.iter = 1'b1;
        if (sts.last_iter) state_next = ST_M1;
      end
      ST_M1: begin
        cmd.mul1 = 1'b1;
        state_next = ST_M2;
      end
      ST_M2: begin
        cmd.mul2 = 1'b1;
        state_next = ST_M3;
      end
      ST_M3: begin
        cmd.mul3 = 1'b1;
        state_next = ST_M4;
      end
      ST_M4: begin
        cmd.mul4 = 1'b1;
        state_next = ST_CMT;
      end
      ST_CMT: begin
        cmd.commit = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

endmodule

@@ rtl/wopi_datapath.sv @@
// ----------------------------------------------------------------------------
// wopi_datapath
// Pose registers, configuration registers, iterative cordic and multipliers.
// ----------------------------------------------------------------------------
module wopi_datapath #(
  parameter int CORDIC_STEPS = 16,
  parameter int WHEEL_COUNT  = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  wopi_pkg::wopi_cmd_t cmd,
  output wopi_pkg::wopi_sts_t sts,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_idx,
  input  logic [31:0]         cfg_data,
  output logic [31:0]         cfg_rdata,
  input  logic signed [15:0]  wa,
  input  logic signed [15:0]  wb,
  input  logic signed [15:0]  wc,
  input  logic signed [15:0]  wd,
  output logic signed [31:0]  pos_x,
  output logic signed [31:0]  pos_y,
  output logic [31:0]         heading,
  output logic [31:0]         elapsed_ticks
);

  localparam int NSTEP = (CORDIC_STEPS < wopi_pkg::ATAN_DEPTH) ?
                         CORDIC_STEPS : wopi_pkg::ATAN_DEPTH;
  localparam logic [4:0] LAST = 5'(NSTEP - 1);

  logic        mode;
  logic [23:0] inv_radius;
  logic [15:0] time_step;
  logic [31:0] start_x, start_y, start_h;
  logic [31:0] cur_x, cur_y, cur_h, ticks;

  // item registers
  logic signed [17:0] bx, by;
  logic signed [43:0] rate;
  logic               flip;
  logic signed [33:0] cx, cy, cz;
  logic [4:0]         step;
  logic signed [52:0] p_xc, p_ys, p_xs, p_yc;
  logic signed [31:0] vx, vy;
  logic signed [63:0] dxp, dyp, rtp;
  logic signed [63:0] dthp;
  logic signed [32:0] rt_s;

  // wheel masking for omni
  logic signed [17:0] w0, w1, w2, w3;
  assign w0 = 18'(wa);
  assign w1 = (WHEEL_COUNT > 1) ? 18'(wb) : 18'sd0;
  assign w2 = (WHEEL_COUNT > 2) ? 18'(wc) : 18'sd0;
  assign w3 = (WHEEL_COUNT > 3) ? 18'(wd) : 18'sd0;

  logic signed [17:0] s_bx, s_by, s_sum, d_sum, d_dif;
  logic signed [35:0] obx, oby;
  logic signed [43:0] orate, drate;
  logic [31:0]        ang;
  logic               fl;

  always_comb begin
    s_bx  = w0 - w1 - w2 + w3;
    s_by  = w0 + w1 - w2 - w3;
    s_sum = w0 + w1 + w2 + w3;
    obx   = (36'(s_bx) * 36'(wopi_pkg::SQRT2_QUARTER)) >>> 16;
    oby   = (36'(s_by) * 36'(wopi_pkg::SQRT2_QUARTER)) >>> 16;
    orate = (44'(s_sum) * $signed({20'd0, inv_radius})) >>> 10;
    d_sum = 18'(wa) + 18'(wb);
    d_dif = 18'(wb) - 18'(wa);
    drate = (44'(d_dif) * $signed({20'd0, inv_radius})) >>> 9;
    fl    = cur_h[30] ^ cur_h[31];
    ang   = fl ? (cur_h - 32'h8000_0000) : cur_h;
  end

  logic signed [33:0] sx, sy, at;
  always_comb begin
    sx = cx >>> step;
    sy = cy >>> step;
    at = wopi_pkg::atan_entry(step);
  end

  // scaled rate fits in 33 bits
  assign rt_s = 33'(rtp >>> 16);

  assign sts.last_iter = (step == LAST);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      flip <= fl;
      cx   <= wopi_pkg::CORDIC_X0;
      cy   <= '0;
      cz   <= 34'($signed(ang));
      step <= '0;
      if (mode) begin
        bx   <= 18'(obx);
        by   <= 18'(oby);
        rate <= orate;
      end else begin
        bx   <= d_sum >>> 1;
        by   <= '0;
        rate <= drate;
      end
    end
    if (cmd.iter) begin
      if (!cz[33]) begin
        cx <= cx - sy;
        cy <= cy + sx;
        cz <= cz - at;
      end else begin
        cx <= cx + sy;
        cy <= cy - sx;
        cz <= cz + at;
      end
      step <= step + 5'd1;
    end
    if (cmd.mul1) begin
      p_xc <= 53'(bx) * 53'(flip ? -cx : cx);
      p_ys <= 53'(by) * 53'(flip ? -cy : cy);
      p_xs <= 53'(bx) * 53'(flip ? -cy : cy);
      p_yc <= 53'(by) * 53'(flip ? -cx : cx);
    end
    if (cmd.mul2) begin
      vx <= 32'((p_xc - p_ys) >>> 22);
      vy <= 32'((p_xs + p_yc) >>> 22);
    end
    if (cmd.mul3) begin
      dxp <= 64'(vx) * $signed({48'd0, time_step});
      dyp <= 64'(vy) * $signed({48'd0, time_step});
      rtp <= 64'(rate) * $signed({48'd0, time_step});
    end
    if (cmd.mul4) begin
      dthp <= 64'(rt_s) * 64'(wopi_pkg::UNITS_PER_RAD);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= 1'b0;
      inv_radius <= 24'd167772;
      time_step  <= 16'd655;
      start_x    <= 32'd655360;
      start_y    <= 32'd655360;
      start_h    <= '0;
      cur_x      <= 32'd655360;
      cur_y      <= 32'd655360;
      cur_h      <= '0;
      ticks      <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        wopi_pkg::REG_MODE:    mode <= cfg_data[0];
        wopi_pkg::REG_INV_RAD: inv_radius <= cfg_data[23:0];
        wopi_pkg::REG_TSTEP:   time_step <= cfg_data[15:0];
        wopi_pkg::REG_START_X: begin
          start_x <= cfg_data; cur_x <= cfg_data; ticks <= '0;
        end
        wopi_pkg::REG_START_Y: begin
          start_y <= cfg_data; cur_y <= cfg_data; ticks <= '0;
        end
        wopi_pkg::REG_START_H: begin
          start_h <= cfg_data; cur_h <= cfg_data; ticks <= '0;
        end
        default: ;
      endcase
    end else if (cmd.commit) begin
      cur_x <= cur_x + 32'(dxp >>> 16);
      cur_y <= cur_y + 32'(dyp >>> 16);
      cur_h <= cur_h + 32'(dthp >>> 24);
      ticks <= ticks + 32'd1;
    end
  end

  always_comb begin
    case (cfg_idx)
      wopi_pkg::REG_MODE:    cfg_rdata = {31'd0, mode};
      wopi_pkg::REG_INV_RAD: cfg_rdata = {8'd0, inv_radius};
      wopi_pkg::REG_TSTEP:   cfg_rdata = {16'd0, time_step};
      wopi_pkg::REG_START_X: cfg_rdata = start_x;
      wopi_pkg::REG_START_Y: cfg_rdata = start_y;
      wopi_pkg::REG_START_H: cfg_rdata = start_h;
      default:               cfg_rdata = '0;
    endcase
  end

  assign pos_x         = cur_x;
  assign pos_y         = cur_y;
  assign heading       = cur_h;
  assign elapsed_ticks = ticks;

endmodule

@@ rtl/wheel_odometry_pose_integrator_top.sv @@
// A request is loaded, rotated by CORDIC_STEPS (capped at 24) cordic iterations,
// then passes the four multiply steps and the pose commit before result valid;
// no new request is taken until the result is taken, so one item is in flight at a time.
// Reset (rst, synchronous) loads register defaults, pose (10.0, 10.0, 0)
// and a zero tick count.
// ----------------------------------------------------------------------------
// wheel_odometry_pose_integrator_top
// Dead-reckoning pose integrator for differential or omni chassis.
// ----------------------------------------------------------------------------
module wheel_odometry_pose_integrator_top #(
  parameter int CORDIC_STEPS = 16,
  parameter int WHEEL_COUNT  = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] wheel_speed_a,
  input  logic signed [15:0] wheel_speed_b,
  input  logic signed [15:0] wheel_speed_c,
  input  logic signed [15:0] wheel_speed_d,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic [31:0]        heading,
  output logic [31:0]        elapsed_ticks
);

  wopi_pkg::wopi_cmd_t cmd;
  wopi_pkg::wopi_sts_t sts;
  logic cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & (paddr[1:0] == 2'd0);

  wopi_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  wopi_datapath #(.CORDIC_STEPS(CORDIC_STEPS), .WHEEL_COUNT(WHEEL_COUNT)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_we), .cfg_idx(paddr[4:2]), .cfg_data(pwdata), .cfg_rdata(prdata),
    .wa(wheel_speed_a), .wb(wheel_speed_b), .wc(wheel_speed_c), .wd(wheel_speed_d),
    .pos_x(pos_x), .pos_y(pos_y), .heading(heading), .elapsed_ticks(elapsed_ticks)
  );

endmodule

@@ tb/wopi_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wopi_checker
// Watches the register port and both request channels of the pose integrator,
// keeps its own pose and register copy, predicts each pose update and
// compares every result with the oldest prediction.
// ----------------------------------------------------------------------------
module wopi_checker #(
  parameter int CORDIC_STEPS = 16,
  parameter int WHEEL_COUNT  = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] wheel_speed_a,
  input  logic signed [15:0] wheel_speed_b,
  input  logic signed [15:0] wheel_speed_c,
  input  logic signed [15:0] wheel_speed_d,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic [31:0]        heading,
  input  logic [31:0]        elapsed_ticks,
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] h;
    logic [31:0] t;
  } pose_t;

  localparam longint ARC_TAB[24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  logic        m_mode;
  logic [23:0] m_inv_rad;
  logic [15:0] m_tstep;
  logic [31:0] p_x, p_y, p_h, p_ticks;
  pose_t       pose_q[$];

  // sin/cos of the heading in Q2.30, iterative rotation with a half-turn fold
  function automatic void rotate_unit(input logic [31:0] ang, output longint cs,
                                      output longint sn);
    logic   flip;
    longint x, y, z, nx;
    int     n;
    flip = ang[31] ^ ang[30];
    x = 652032874;
    y = 0;
    n = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
    if (flip) ang = ang - 32'h8000_0000;
    z = longint'(signed'(ang));
    for (int i = 0; i < n; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - ARC_TAB[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + ARC_TAB[i];
      end
      x = nx;
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endfunction

  function automatic pose_t advance_pose(input logic signed [15:0] a, b, c, d);
    longint w[4], bx, by, rate, cs, sn, vx, vy, dx, dy, dth;
    pose_t  r;
    w[0] = a;
    w[1] = b;
    w[2] = c;
    w[3] = d;
    if (m_mode) begin
      for (int i = 0; i < 4; i++) if (i >= WHEEL_COUNT) w[i] = 0;
      bx = ((w[0] - w[1] - w[2] + w[3]) * 23170) >>> 16;
      by = ((w[0] + w[1] - w[2] - w[3]) * 23170) >>> 16;
      rate = ((w[0] + w[1] + w[2] + w[3]) * longint'(m_inv_rad)) >>> 10;
    end else begin
      bx = (w[0] + w[1]) >>> 1;
      by = 0;
      rate = ((w[1] - w[0]) * longint'(m_inv_rad)) >>> 9;
    end
    rotate_unit(p_h, cs, sn);
    vx = (bx * cs - by * sn) >>> 22;
    vy = (bx * sn + by * cs) >>> 22;
    dx = (vx * longint'(m_tstep)) >>> 16;
    dy = (vy * longint'(m_tstep)) >>> 16;
    dth = (((rate * longint'(m_tstep)) >>> 16) * 683565276) >>> 24;
    p_x = p_x + dx[31:0];
    p_y = p_y + dy[31:0];
    p_h = p_h + dth[31:0];
    p_ticks = p_ticks + 1;
    r.x = p_x;
    r.y = p_y;
    r.h = p_h;
    r.t = p_ticks;
    return r;
  endfunction

  assign pending = pose_q.size();

  always @(posedge clk) begin
    pose_t got, want;
    if (rst) begin
      m_mode = 1'b0;
      m_inv_rad = 24'd167772;
      m_tstep = 16'd655;
      p_x = 32'd655360;
      p_y = 32'd655360;
      p_h = '0;
      p_ticks = '0;
      pose_q.delete();
      errors = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          wopi_pkg::REG_MODE:    m_mode = pwdata[0];
          wopi_pkg::REG_INV_RAD: m_inv_rad = pwdata[23:0];
          wopi_pkg::REG_TSTEP:   m_tstep = pwdata[15:0];
          wopi_pkg::REG_START_X: begin p_x = pwdata; p_ticks = '0; end
          wopi_pkg::REG_START_Y: begin p_y = pwdata; p_ticks = '0; end
          wopi_pkg::REG_START_H: begin p_h = pwdata; p_ticks = '0; end
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = {pos_x, pos_y, heading, elapsed_ticks};
        if (pose_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %h", $time, got);
        end else begin
          want = pose_q.pop_front();
          if (got.x !== want.x) begin
            errors++;
            $display("%0t: pos_x expected %h actual %h", $time, want.x, got.x);
          end
          if (got.y !== want.y) begin
            errors++;
            $display("%0t: pos_y expected %h actual %h", $time, want.y, got.y);
          end
          if (got.h !== want.h) begin
            errors++;
            $display("%0t: heading expected %h actual %h", $time, want.h, got.h);
          end
          if (got.t !== want.t) begin
            errors++;
            $display("%0t: elapsed_ticks expected %h actual %h", $time, want.t, got.t);
          end
        end
      end
      if (in_valid && !in_stall)
        pose_q.push_back(advance_pose(wheel_speed_a, wheel_speed_b, wheel_speed_c,
                                      wheel_speed_d));
    end
  end

endmodule

@@ tb/tb_wheel_odometry_pose_integrator_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_wheel_odometry_pose_integrator_top
// Drives register settings and wheel speed requests into the pose integrator
// with random idling on both sides; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_wheel_odometry_pose_integrator_top;

  localparam int WATCHDOG_LIMIT = 20000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] wheel_speed_a = '0, wheel_speed_b = '0;
  logic signed [15:0] wheel_speed_c = '0, wheel_speed_d = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] pos_x, pos_y;
  logic [31:0]        heading, elapsed_ticks;
  int                 errors, pending;
  int                 send_idle_pct = 0, recv_stall_pct = 0;
  logic               hold_go = 1'b0;
  int                 hold_cnt = 0;
  int                 quiet_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  wheel_odometry_pose_integrator_top uut (.*);

  wopi_checker chk (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid, .in_stall, .wheel_speed_a, .wheel_speed_b, .wheel_speed_c,
    .wheel_speed_d, .out_valid, .out_stall, .pos_x, .pos_y, .heading,
    .elapsed_ticks, .errors, .pending
  );

  // receiver stalls, with a long hold-off when requested
  always @(posedge clk) begin
    if (hold_go) begin
      hold_cnt <= 400;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    wait (pending == 0);
    repeat (30) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // called at a rising edge, returns at the edge where the request is taken or after a random idle gap
  task automatic send_tick(input logic [15:0] a, b, c, d);
    logic taken;
    in_valid <= 1'b1;
    wheel_speed_a <= a;
    wheel_speed_b <= b;
    wheel_speed_c <= c;
    wheel_speed_d <= d;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic logic [15:0] pick_speed();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      1, 2, 3: return 16'($urandom);
      default: return 16'($urandom_range(0, 4000) - 2000);
    endcase
  endfunction

  task automatic random_ticks(input int n);
    for (int i = 0; i < n; i++)
      send_tick(pick_speed(), pick_speed(), pick_speed(), pick_speed());
  endtask

  task automatic set_phase(input logic mode, input logic [23:0] inv_rad,
                           input logic [15:0] tstep, input logic [31:0] sx, sy, sh);
    in_valid <= 1'b0;
    reg_write(wopi_pkg::REG_MODE, {31'($urandom), mode});
    reg_write(wopi_pkg::REG_INV_RAD, {8'($urandom), inv_rad});
    reg_write(wopi_pkg::REG_TSTEP, {16'($urandom), tstep});
    reg_write(wopi_pkg::REG_START_X, sx);
    reg_write(wopi_pkg::REG_START_Y, sy);
    reg_write(wopi_pkg::REG_START_H, sh);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings, differential drive
    send_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_tick(16'h7FFF, 16'h7FFF, 16'h1234, 16'h8000);
    send_tick(16'h8000, 16'h8000, 16'h0000, 16'h0000);
    send_tick(16'h8000, 16'h7FFF, 16'h0000, 16'h0000);
    send_tick(16'h7FFF, 16'h8000, 16'h0000, 16'h0000);
    send_tick(16'h0100, 16'h0200, 16'h7FFF, 16'h7FFF);
    // writes past the register list are dropped
    in_valid <= 1'b0;
    reg_write(3'd6, 32'hFFFF_FFFF);
    reg_write(3'd7, 32'h0000_0001);
    // omni with maximum inverse radius and step
    set_phase(1'b1, 24'hFF_FFFF, 16'hFFFF, 32'h7FFF_FFF0, 32'h8000_0010, 32'hC000_0000);
    send_tick(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_tick(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_tick(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
    send_tick(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
    send_tick(16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA);
    send_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    // heading at the fold boundaries
    set_phase(1'b0, 24'h00_0000, 16'h0000, 32'h0, 32'hFFFF_FFFF, 32'h4000_0000);
    send_tick(16'h7FFF, 16'h8000, 16'h0000, 16'h0000);
    set_phase(1'b0, 24'hFF_FFFF, 16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hBFFF_FFFF);
    send_tick(16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000);
    send_tick(16'h8000, 16'h7FFF, 16'h0000, 16'h0000);
    send_tick(16'h7FFF, 16'h8000, 16'h0000, 16'h0000);
    set_phase(1'b1, 24'd167772, 16'd655, 32'd655360, 32'd655360, 32'hFFFF_FFFF);
    send_tick(16'h1000, 16'h2000, 16'h3000, 16'h4000);
    send_tick(16'hF000, 16'h2000, 16'hD000, 16'h4000);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin send_idle_pct = 24; recv_stall_pct = 77; end
        1: begin send_idle_pct = 77; recv_stall_pct = 24; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      case (ph)
        0: set_phase(1'b0, 24'd167772, 16'd655, 32'd655360, 32'd655360, 32'h0);
        1: set_phase(1'b1, 24'($urandom), 16'($urandom), $urandom, $urandom, $urandom);
        2: set_phase(1'b0, 24'hFF_FFFF, 16'hFFFF, $urandom, $urandom, $urandom);
        3: set_phase(1'b1, 24'd1, 16'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        4: set_phase(1'b0, 24'($urandom), 16'($urandom), $urandom, $urandom, $urandom);
        default: set_phase(1'b1, 24'hFF_FFFF, 16'hFFFF, $urandom, $urandom, $urandom);
      endcase
      random_ticks(150);
      if (ph == 4) begin
        // long receiver hold-off while requests keep coming
        in_valid <= 1'b0;
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
        random_ticks(5);
        // sender pause until the pipeline drains
        in_valid <= 1'b0;
        wait (pending == 0);
        @(posedge clk);
      end
      random_ticks(160);
    end

    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (40) @(posedge clk);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
